FILE: rtl/eocc_pkg.sv
package eocc_pkg;

  // Store sizes and coordinate width.
  localparam int unsigned CLOUD_DEPTH  = 1024;
  localparam int unsigned OBJECT_DEPTH = 64;
  localparam int unsigned COORD_WIDTH  = 24;

  // Derived widths.
  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned RW   = CW - 1;
  localparam int unsigned CAW  = (CLOUD_DEPTH > 1) ? $clog2(CLOUD_DEPTH) : 1;
  localparam int unsigned OAW  = (OBJECT_DEPTH > 1) ? $clog2(OBJECT_DEPTH) : 1;
  localparam int unsigned CLW  = $clog2(CLOUD_DEPTH + 1);
  localparam int unsigned OLW  = $clog2(OBJECT_DEPTH + 1);
  localparam int unsigned IW   = (CAW > OAW) ? CAW : OAW;

  // Multiplier widths: the shared unit takes one digit of operand A a cycle.
  localparam int unsigned DIG  = 8;
  localparam int unsigned AW   = 2 * CW;
  localparam int unsigned NDIG = (AW + DIG - 1) / DIG;
  localparam int unsigned AXW  = NDIG * DIG;
  localparam int unsigned SCW  = $clog2(NDIG + 1);
  localparam int unsigned R2W  = 2 * RW;
  localparam int unsigned KW   = 4 * RW;
  localparam int unsigned ALLW = 6 * RW;
  localparam int unsigned D2W  = 2 * CW;
  localparam int unsigned PW   = 2 * CW + 4 * RW + 2;
  localparam int unsigned EW   = 3 * CW;

  typedef logic [CW-1:0]   coord_t;
  typedef logic [RW-1:0]   rad_t;
  typedef logic [CAW-1:0]  caddr_t;
  typedef logic [OAW-1:0]  oaddr_t;
  typedef logic [CLW-1:0]  ccnt_t;
  typedef logic [OLW-1:0]  ocnt_t;
  typedef logic [IW-1:0]   idx_t;
  typedef logic [IW:0]     idx1_t;
  typedef logic [AXW-1:0]  opa_t;
  typedef logic [PW-1:0]   wide_t;
  typedef logic [SCW-1:0]  step_t;
  typedef logic [EW-1:0]   entry_t;

  // Command codes of an input word.
  typedef enum logic [2:0] {
    CMD_CLR_CLOUD = 3'd0,
    CMD_APP_CLOUD = 3'd1,
    CMD_CLR_OBJ   = 3'd2,
    CMD_APP_OBJ   = 3'd3,
    CMD_QUERY     = 3'd4
  } cmd_code_t;

  // Multiplier operations, in the order the controller issues them.
  typedef enum logic [3:0] {
    OP_RX2, OP_RY2, OP_RZ2, OP_KA, OP_KB, OP_KC, OP_ALL,
    OP_SQX, OP_TX, OP_SQY, OP_TY, OP_SQZ, OP_TZ
  } op_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic   load_q;
    logic   cloud_we;
    caddr_t cloud_wa;
    logic   obj_we;
    oaddr_t obj_wa;
    logic   rd_en;
    logic   rd_obj;
    caddr_t cloud_ra;
    oaddr_t obj_ra;
    logic   mac_start;
    op_t    op;
  } ctl_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic mac_done;
    logic hit;
  } sts_t;

endpackage

FILE: rtl/ellipsoid_obstacle_collision_check.sv
// Channel   Ports                                         Handshake
// input     in_command, in_pos_*, in_radius_*             start high while busy low
// result    out_collision, out_append_dropped             out_valid, one cycle
//
// Clear and append words never raise busy; they give no result.
// A query forms seven setup products, then checks the N stored points in turn (NDIG = 6
// digits of 8 bits): one shared 8-bit by 142-bit multiplier forms every product,
// six of them per point. A query stops at the first point found inside.
// Reset is synchronous and active low; it empties both stores and clears the flag.
// The result is shown for one cycle; the receiver cannot stall it.
module ellipsoid_obstacle_collision_check (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       in_command,
  input  eocc_pkg::coord_t in_pos_x,
  input  eocc_pkg::coord_t in_pos_y,
  input  eocc_pkg::coord_t in_pos_z,
  input  eocc_pkg::rad_t   in_radius_x,
  input  eocc_pkg::rad_t   in_radius_y,
  input  eocc_pkg::rad_t   in_radius_z,
  output logic             out_valid,
  output logic             out_collision,
  output logic             out_append_dropped
);

  eocc_pkg::ctl_t ctl;
  eocc_pkg::sts_t sts;

  // Sequencer with store counts and the sticky flag.
  eocc_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .in_command         (in_command),
    .busy               (busy),
    .out_valid          (out_valid),
    .out_collision      (out_collision),
    .out_append_dropped (out_append_dropped),
    .ctl                (ctl),
    .sts                (sts)
  );

  // Stores, query registers and the shared multiplier.
  eocc_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .in_pos_x    (in_pos_x),
    .in_pos_y    (in_pos_y),
    .in_pos_z    (in_pos_z),
    .in_radius_x (in_radius_x),
    .in_radius_y (in_radius_y),
    .in_radius_z (in_radius_z),
    .sts         (sts)
  );

endmodule

FILE: rtl/eocc_datapath.sv
module eocc_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  eocc_pkg::ctl_t      ctl,
  input  eocc_pkg::coord_t    in_pos_x,
  input  eocc_pkg::coord_t    in_pos_y,
  input  eocc_pkg::coord_t    in_pos_z,
  input  eocc_pkg::rad_t      in_radius_x,
  input  eocc_pkg::rad_t      in_radius_y,
  input  eocc_pkg::rad_t      in_radius_z,
  output eocc_pkg::sts_t      sts
);

  // Magnitude of the difference of two signed coordinates.
  function automatic eocc_pkg::coord_t abs_diff(eocc_pkg::coord_t a, eocc_pkg::coord_t b);
    logic [eocc_pkg::CW:0] d;
    d = {a[eocc_pkg::CW-1], a} - {b[eocc_pkg::CW-1], b};
    if (d[eocc_pkg::CW]) begin
      d = (~d) + {{eocc_pkg::CW{1'b0}}, 1'b1};
    end
    return d[eocc_pkg::CW-1:0];
  endfunction

  // Point stores.
  eocc_pkg::entry_t cloud_mem [eocc_pkg::CLOUD_DEPTH];
  eocc_pkg::entry_t obj_mem   [eocc_pkg::OBJECT_DEPTH];
  eocc_pkg::entry_t cloud_q_r;
  eocc_pkg::entry_t obj_q_r;
  logic             rd_obj_r;

  // Query registers and precomputed products.
  eocc_pkg::coord_t qx_r, qy_r, qz_r;
  eocc_pkg::rad_t   rx_r, ry_r, rz_r;
  logic [eocc_pkg::R2W-1:0]  rx2_r, ry2_r, rz2_r;
  logic [eocc_pkg::KW-1:0]   ka_r, kb_r, kc_r;
  logic [eocc_pkg::ALLW-1:0] all_r;
  logic [eocc_pkg::D2W-1:0]  d2_r;
  eocc_pkg::wide_t           sum_r;

  // Shared digit-serial multiplier.
  eocc_pkg::opa_t  a_r, a_sel;
  eocc_pkg::wide_t b_r, b_sel, acc_r, acc_nxt;
  eocc_pkg::op_t   op_r;
  eocc_pkg::step_t cnt_r;
  logic            done_r;
  logic [eocc_pkg::PW+eocc_pkg::DIG-1:0] prod;

  eocc_pkg::entry_t pt;
  eocc_pkg::coord_t mx, my, mz;

  assign pt = rd_obj_r ? obj_q_r : cloud_q_r;
  assign mx = abs_diff(qx_r, pt[eocc_pkg::CW-1:0]);
  assign my = abs_diff(qy_r, pt[2*eocc_pkg::CW-1:eocc_pkg::CW]);
  assign mz = abs_diff(qz_r, pt[3*eocc_pkg::CW-1:2*eocc_pkg::CW]);

  // Operand selection for each operation.
  always_comb begin
    unique case (ctl.op)
      eocc_pkg::OP_RX2: begin
        a_sel = eocc_pkg::opa_t'(rx_r);  b_sel = eocc_pkg::wide_t'(rx_r);
      end
      eocc_pkg::OP_RY2: begin
        a_sel = eocc_pkg::opa_t'(ry_r);  b_sel = eocc_pkg::wide_t'(ry_r);
      end
      eocc_pkg::OP_RZ2: begin
        a_sel = eocc_pkg::opa_t'(rz_r);  b_sel = eocc_pkg::wide_t'(rz_r);
      end
      eocc_pkg::OP_KA: begin
        a_sel = eocc_pkg::opa_t'(ry2_r); b_sel = eocc_pkg::wide_t'(rz2_r);
      end
      eocc_pkg::OP_KB: begin
        a_sel = eocc_pkg::opa_t'(rx2_r); b_sel = eocc_pkg::wide_t'(rz2_r);
      end
      eocc_pkg::OP_KC: begin
        a_sel = eocc_pkg::opa_t'(rx2_r); b_sel = eocc_pkg::wide_t'(ry2_r);
      end
      eocc_pkg::OP_ALL: begin
        a_sel = eocc_pkg::opa_t'(rx2_r); b_sel = eocc_pkg::wide_t'(ka_r);
      end
      eocc_pkg::OP_SQX: begin
        a_sel = eocc_pkg::opa_t'(mx);    b_sel = eocc_pkg::wide_t'(mx);
      end
      eocc_pkg::OP_SQY: begin
        a_sel = eocc_pkg::opa_t'(my);    b_sel = eocc_pkg::wide_t'(my);
      end
      eocc_pkg::OP_SQZ: begin
        a_sel = eocc_pkg::opa_t'(mz);    b_sel = eocc_pkg::wide_t'(mz);
      end
      eocc_pkg::OP_TX: begin
        a_sel = eocc_pkg::opa_t'(d2_r);  b_sel = eocc_pkg::wide_t'(ka_r);
      end
      eocc_pkg::OP_TY: begin
        a_sel = eocc_pkg::opa_t'(d2_r);  b_sel = eocc_pkg::wide_t'(kb_r);
      end
      eocc_pkg::OP_TZ: begin
        a_sel = eocc_pkg::opa_t'(d2_r);  b_sel = eocc_pkg::wide_t'(kc_r);
      end
      default: begin
        a_sel = '0;                      b_sel = '0;
      end
    endcase
  end

  // One digit of A times all of B, added to the running product.
  assign prod    = a_r[eocc_pkg::DIG-1:0] * b_r;
  assign acc_nxt = acc_r + prod[eocc_pkg::PW-1:0];

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.mac_start) begin
        cnt_r <= eocc_pkg::step_t'(eocc_pkg::NDIG);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == eocc_pkg::step_t'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Multiplier operands, accumulation and write-back of finished products.
  always_ff @(posedge clk) begin
    if (ctl.mac_start) begin
      op_r  <= ctl.op;
      a_r   <= a_sel;
      b_r   <= b_sel;
      acc_r <= '0;
    end else if (cnt_r != '0) begin
      a_r   <= a_r >> eocc_pkg::DIG;
      b_r   <= b_r << eocc_pkg::DIG;
      acc_r <= acc_nxt;
      if (cnt_r == eocc_pkg::step_t'(1)) begin
        unique case (op_r)
          eocc_pkg::OP_RX2: rx2_r <= acc_nxt[eocc_pkg::R2W-1:0];
          eocc_pkg::OP_RY2: ry2_r <= acc_nxt[eocc_pkg::R2W-1:0];
          eocc_pkg::OP_RZ2: rz2_r <= acc_nxt[eocc_pkg::R2W-1:0];
          eocc_pkg::OP_KA:  ka_r  <= acc_nxt[eocc_pkg::KW-1:0];
          eocc_pkg::OP_KB:  kb_r  <= acc_nxt[eocc_pkg::KW-1:0];
          eocc_pkg::OP_KC:  kc_r  <= acc_nxt[eocc_pkg::KW-1:0];
          eocc_pkg::OP_ALL: all_r <= acc_nxt[eocc_pkg::ALLW-1:0];
          eocc_pkg::OP_SQX,
          eocc_pkg::OP_SQY,
          eocc_pkg::OP_SQZ: d2_r  <= acc_nxt[eocc_pkg::D2W-1:0];
          eocc_pkg::OP_TX:  sum_r <= acc_nxt;
          eocc_pkg::OP_TY,
          eocc_pkg::OP_TZ:  sum_r <= sum_r + acc_nxt;
          default: ;
        endcase
      end
    end
  end

  // Query word capture.
  always_ff @(posedge clk) begin
    if (ctl.load_q) begin
      qx_r <= in_pos_x;
      qy_r <= in_pos_y;
      qz_r <= in_pos_z;
      rx_r <= in_radius_x;
      ry_r <= in_radius_y;
      rz_r <= in_radius_z;
    end
  end

  // Store writes and registered reads.
  always_ff @(posedge clk) begin
    if (ctl.cloud_we) begin
      cloud_mem[ctl.cloud_wa] <= {in_pos_z, in_pos_y, in_pos_x};
    end
    if (ctl.rd_en && !ctl.rd_obj) begin
      cloud_q_r <= cloud_mem[ctl.cloud_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.obj_we) begin
      obj_mem[ctl.obj_wa] <= {in_pos_z, in_pos_y, in_pos_x};
    end
    if (ctl.rd_en && ctl.rd_obj) begin
      obj_q_r <= obj_mem[ctl.obj_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_obj_r <= ctl.rd_obj;
    end
  end

  assign sts.mac_done = done_r;
  assign sts.hit      = sum_r < eocc_pkg::wide_t'(all_r);

endmodule

FILE: rtl/eocc_ctrl.sv
module eocc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2:0]      in_command,
  output logic            busy,
  output logic            out_valid,
  output logic            out_collision,
  output logic            out_append_dropped,
  output eocc_pkg::ctl_t  ctl,
  input  eocc_pkg::sts_t  sts
);

  typedef enum logic [2:0] {
    S_IDLE, S_ISSUE, S_WAIT, S_READ, S_CHECK
  } state_t;

  state_t          state_r;
  eocc_pkg::op_t   op_r;
  eocc_pkg::ccnt_t cloud_cnt_r;
  eocc_pkg::ocnt_t obj_cnt_r;
  eocc_pkg::idx_t  idx_r;
  logic            src_obj_r;
  logic            dropped_r;
  logic            valid_r;
  logic            coll_r;
  logic            drop_out_r;
  logic            accept;
  logic            cloud_full;
  logic            obj_full;
  logic            cloud_more;
  logic            obj_more;
  eocc_pkg::idx1_t idx_inc;

  assign accept     = start && (state_r == S_IDLE);
  assign cloud_full = cloud_cnt_r >= eocc_pkg::ccnt_t'(eocc_pkg::CLOUD_DEPTH);
  assign obj_full   = obj_cnt_r >= eocc_pkg::ocnt_t'(eocc_pkg::OBJECT_DEPTH);
  assign idx_inc    = {1'b0, idx_r} + 1'b1;
  assign cloud_more = idx_inc < eocc_pkg::idx1_t'(cloud_cnt_r);
  assign obj_more   = idx_inc < eocc_pkg::idx1_t'(obj_cnt_r);

  // Commands to the datapath.
  always_comb begin
    ctl           = '0;
    ctl.load_q    = accept && (in_command == eocc_pkg::CMD_QUERY);
    ctl.cloud_we  = accept && (in_command == eocc_pkg::CMD_APP_CLOUD) && !cloud_full;
    ctl.cloud_wa  = cloud_cnt_r[eocc_pkg::CAW-1:0];
    ctl.obj_we    = accept && (in_command == eocc_pkg::CMD_APP_OBJ) && !obj_full;
    ctl.obj_wa    = obj_cnt_r[eocc_pkg::OAW-1:0];
    ctl.rd_en     = (state_r == S_READ);
    ctl.rd_obj    = src_obj_r;
    ctl.cloud_ra  = idx_r[eocc_pkg::CAW-1:0];
    ctl.obj_ra    = idx_r[eocc_pkg::OAW-1:0];
    ctl.mac_start = (state_r == S_ISSUE);
    ctl.op        = op_r;
  end

  // Sequencer: command handling, query setup, then one point after another.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= eocc_pkg::OP_RX2;
      cloud_cnt_r <= '0;
      obj_cnt_r   <= '0;
      idx_r       <= '0;
      src_obj_r   <= 1'b0;
      dropped_r   <= 1'b0;
      valid_r     <= 1'b0;
      coll_r      <= 1'b0;
      drop_out_r  <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            unique case (in_command)
              eocc_pkg::CMD_CLR_CLOUD: cloud_cnt_r <= '0;
              eocc_pkg::CMD_CLR_OBJ:   obj_cnt_r   <= '0;
              eocc_pkg::CMD_APP_CLOUD: begin
                if (cloud_full) begin
                  dropped_r <= 1'b1;
                end else begin
                  cloud_cnt_r <= cloud_cnt_r + 1'b1;
                end
              end
              eocc_pkg::CMD_APP_OBJ: begin
                if (obj_full) begin
                  dropped_r <= 1'b1;
                end else begin
                  obj_cnt_r <= obj_cnt_r + 1'b1;
                end
              end
              eocc_pkg::CMD_QUERY: begin
                op_r    <= eocc_pkg::OP_RX2;
                state_r <= S_ISSUE;
              end
              default: ;
            endcase
          end
        end
        S_ISSUE: state_r <= S_WAIT;
        S_WAIT: begin
          if (sts.mac_done) begin
            if (op_r == eocc_pkg::OP_ALL) begin
              // Setup done: pick the first stored point, if any.
              idx_r <= '0;
              if (cloud_cnt_r != '0) begin
                src_obj_r <= 1'b0;
                state_r   <= S_READ;
              end else if (obj_cnt_r != '0) begin
                src_obj_r <= 1'b1;
                state_r   <= S_READ;
              end else begin
                valid_r    <= 1'b1;
                coll_r     <= 1'b0;
                drop_out_r <= dropped_r;
                state_r    <= S_IDLE;
              end
            end else if (op_r == eocc_pkg::OP_TZ) begin
              state_r <= S_CHECK;
            end else begin
              op_r    <= eocc_pkg::op_t'(op_r + 1'b1);
              state_r <= S_ISSUE;
            end
          end
        end
        S_READ: begin
          op_r    <= eocc_pkg::OP_SQX;
          state_r <= S_ISSUE;
        end
        S_CHECK: begin
          if (sts.hit) begin
            valid_r    <= 1'b1;
            coll_r     <= 1'b1;
            drop_out_r <= dropped_r;
            state_r    <= S_IDLE;
          end else if (!src_obj_r && cloud_more) begin
            idx_r   <= idx_inc[eocc_pkg::IW-1:0];
            state_r <= S_READ;
          end else if (!src_obj_r && (obj_cnt_r != '0)) begin
            idx_r     <= '0;
            src_obj_r <= 1'b1;
            state_r   <= S_READ;
          end else if (src_obj_r && obj_more) begin
            idx_r   <= idx_inc[eocc_pkg::IW-1:0];
            state_r <= S_READ;
          end else begin
            valid_r    <= 1'b1;
            coll_r     <= 1'b0;
            drop_out_r <= dropped_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = valid_r;
  assign out_collision      = coll_r;
  assign out_append_dropped = drop_out_r;

endmodule
